[rtl/arw_pkg.sv]
package arw_pkg;

    // Width of the sliding replay window, 8 to 64.
    localparam int WIN_BITS  = 64;
    localparam int WIN_IDX_W = $clog2(WIN_BITS);

    localparam int SEQ_W = 32;

    localparam logic [WIN_BITS-1:0] WIN_ONE = WIN_BITS'(1);
    localparam logic [SEQ_W-1:0]    WIN_LIMIT = SEQ_W'(WIN_BITS);

    localparam logic [SEQ_W-1:0] REKEY_THRESHOLD_RESET = 32'hF000_0000;

    // Command codes carried in the input tuser.
    localparam logic [1:0] CMD_CHECK = 2'd0;
    localparam logic [1:0] CMD_TX    = 2'd1;
    localparam logic [1:0] CMD_REKEY = 2'd2;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [SEQ_W-1:0] rx_seq;
        logic             session_established;
    } in_item_t;

    typedef struct packed {
        logic             accepted;
        logic [SEQ_W-1:0] tx_seq;
        logic             aborted;
        logic             rekey_needed;
    } out_item_t;

endpackage

[rtl/arw_in_stage.sv]
module arw_in_stage
    import arw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic [1:0]            s_tuser,
    input  logic                  out_ready,
    output logic                  item_valid,
    output in_item_t              item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_tready   = !valid_reg || out_ready;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.cmd                 <= s_tuser;
            item_reg.rx_seq              <= s_tdata[SEQ_W-1:0];
            item_reg.session_established <= s_tdata[SEQ_W];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[rtl/arw_guard.sv]
module arw_guard
    import arw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  in_item_t         item,
    input  logic             cfg_we,
    input  logic [SEQ_W-1:0] cfg_wdata,
    output out_item_t        result
);

    logic [SEQ_W-1:0]    highest_rx_seq_reg, highest_rx_seq_next;
    logic [WIN_BITS-1:0] seen_window_reg, seen_window_next;
    logic [SEQ_W-1:0]    last_tx_seq_reg, last_tx_seq_next;
    logic                error_latched_reg, error_latched_next;
    logic [SEQ_W-1:0]    rekey_threshold_reg;

    logic [SEQ_W-1:0]    dist_up;
    logic [SEQ_W-1:0]    dist_dn;
    logic [SEQ_W-1:0]    tx_inc;
    logic                seq_newer;
    logic                acc;
    logic [SEQ_W-1:0]    txv;

    assign dist_up   = item.rx_seq - highest_rx_seq_reg;
    assign dist_dn   = highest_rx_seq_reg - item.rx_seq;
    assign seq_newer = item.rx_seq > highest_rx_seq_reg;
    assign tx_inc    = last_tx_seq_reg + 1'b1;

    always_comb
    begin
        highest_rx_seq_next = highest_rx_seq_reg;
        seen_window_next    = seen_window_reg;
        last_tx_seq_next    = last_tx_seq_reg;
        error_latched_next  = error_latched_reg;
        acc                 = 1'b0;
        txv                 = '0;
        case (item.cmd)
            CMD_CHECK:
            begin
                if (item.rx_seq != '0)
                begin
                    if (seq_newer)
                    begin
                        // Slide the window up; a jump of its full width or more starts it over.
                        if (dist_up < WIN_LIMIT)
                        begin
                            seen_window_next = (seen_window_reg << dist_up[WIN_IDX_W-1:0])
                                               | WIN_ONE;
                        end
                        else
                        begin
                            seen_window_next = WIN_ONE;
                        end
                        highest_rx_seq_next = item.rx_seq;
                        acc                 = 1'b1;
                    end
                    else if (dist_dn < WIN_LIMIT)
                    begin
                        if (!seen_window_reg[dist_dn[WIN_IDX_W-1:0]])
                        begin
                            seen_window_next[dist_dn[WIN_IDX_W-1:0]] = 1'b1;
                            acc                                       = 1'b1;
                        end
                    end
                end
            end
            CMD_TX:
            begin
                last_tx_seq_next = tx_inc;
                txv              = tx_inc;
                if (tx_inc == '0)
                begin
                    error_latched_next = 1'b1;
                end
                else
                begin
                    acc = 1'b1;
                end
            end
            CMD_REKEY:
            begin
                highest_rx_seq_next = '0;
                seen_window_next    = '0;
                last_tx_seq_next    = '0;
            end
            default:
            begin
                acc = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            highest_rx_seq_reg  <= '0;
            seen_window_reg     <= '0;
            last_tx_seq_reg     <= '0;
            error_latched_reg   <= 1'b0;
            rekey_threshold_reg <= REKEY_THRESHOLD_RESET;
        end
        else
        begin
            if (step)
            begin
                highest_rx_seq_reg <= highest_rx_seq_next;
                seen_window_reg    <= seen_window_next;
                last_tx_seq_reg    <= last_tx_seq_next;
                error_latched_reg  <= error_latched_next;
            end
            if (cfg_we)
            begin
                rekey_threshold_reg <= cfg_wdata;
            end
        end
    end

    assign result.accepted     = acc;
    assign result.tx_seq       = txv;
    assign result.aborted      = error_latched_next;
    assign result.rekey_needed = item.session_established &&
                                 ((last_tx_seq_next > rekey_threshold_reg) ||
                                  (highest_rx_seq_next > rekey_threshold_reg));

endmodule

[rtl/arw_out_stage.sv]
module arw_out_stage
    import arw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  out_item_t              result,
    output logic                   out_ready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t result_reg;

    assign out_ready  = !valid_reg || m_tready;
    assign valid_next = out_ready ? item_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && item_valid)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'b0, result_reg.rekey_needed, result_reg.aborted,
                       result_reg.tx_seq, result_reg.accepted};

endmodule

[rtl/anti_replay_window_with_seq_counter.sv]
// Channel  | Direction | Signals                      | Contents
// ---------+-----------+------------------------------+-------------------------------------
// s_*      | in        | s_tvalid s_tready s_tdata    | command item, tuser = cmd
//          |           | s_tuser                      |
// m_*      | out       | m_tvalid m_tready m_tdata    | one result item per command item
// cfg_*    | in        | cfg_we cfg_wdata             | rekey_threshold write, no read-back
//
// Each item is held in the input register and then moves on to the output register,
// and one item is taken every cycle while m_tready does not stall the output.
// The window shift, the sequence compares and the rekey compare all sit in the single
// stage between the two registers, where the session state is also updated.
// rst_n clears the valid flags, the counters, the window and the abort latch, and loads
// the rekey threshold with its default. A stall on m_tready holds the output register
// and, through the same ready chain, the input register; nothing is lost or repeated.
module anti_replay_window_with_seq_counter
    import arw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [31:0] rx_seq, [32] session_established, [39:33] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // [1:0] cmd
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] accepted, [32:1] tx_seq, [33] aborted, [34] rekey_needed, [39:35] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_we,
    input  logic [SEQ_W-1:0]       cfg_wdata
);

    logic      out_ready;
    logic      item_valid;
    in_item_t  item;
    out_item_t result;

    // The input register holds the item that is worked on this cycle.
    arw_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .out_ready  (out_ready),
        .item_valid (item_valid),
        .item       (item)
    );

    // The session state advances exactly when the item moves into the output register.
    arw_guard u_guard (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (item_valid && out_ready),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

    arw_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .out_ready  (out_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
